// ===== rtl/icy_pkg.sv =====
// Shared types and constants for the ICY metadata stream demultiplexer.
`timescale 1ns / 1ps

package icy_pkg;

    // Stream phase: audio bytes, the length byte, or inside a metadata block
    typedef enum logic [1:0] {
        PH_AUDIO  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_META   = 2'd2
    } phase_t;

    // Title search state within one metadata block
    typedef enum logic [1:0] {
        TP_SEARCH  = 2'd0,
        TP_CAPTURE = 2'd1,
        TP_DONE    = 2'd2
    } title_phase_t;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_AUDIO         = 2'd0,
        KIND_TITLE_CHAR    = 2'd1,
        KIND_TITLE_DONE    = 2'd2,
        KIND_TITLE_ABANDON = 2'd3
    } kind_t;

    // One queued transaction group: first result, plus an optional abandon marker
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       two;
    } entry_t;

    localparam int CFG_WIDTH   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [3:0] PATTERN_LEN = 4'd13;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_S      = 8'h73;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Characters of streamtitle=' in lower case
    function automatic logic [7:0] pattern_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h73; // s
            4'd1:    c = 8'h74; // t
            4'd2:    c = 8'h72; // r
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h6D; // m
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h69; // i
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h6C; // l
            4'd10:   c = 8'h65; // e
            4'd11:   c = 8'h3D; // =
            4'd12:   c = 8'h27; // '
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/icy_metadata_demux.sv =====
// Top level of the ICY metadata stream demultiplexer.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_we, cfg_wdata[15:0]                   | in
//  in      | in_valid, in_ready, in_byte[7:0]          | in
//  out     | out_valid, out_ready, out_kind[1:0],      | out
//          | out_byte[7:0], out_last                   |
//
// One input byte is accepted per cycle while the 4-entry result queue has room.
// Each byte makes 0, 1 or 2 output transactions; the output register issues one
// per cycle unless out_ready stalls it, so a title character plus the abandon
// marker form two transactions. Results pass a queue slot, then the output register.
// Reset is asynchronous and clears all parse state and the interval register.
// A stalled output fills the queue, and in_ready drops only once it is full.
`timescale 1ns / 1ps

module icy_metadata_demux #(
    parameter int INTERVAL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icy_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_kind,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);

    logic            q_full;
    logic            q_push;
    logic            q_empty;
    logic            q_pop;
    icy_pkg::entry_t q_entry;
    icy_pkg::entry_t q_head;

    // Parser front end
    icy_front #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Decoupling queue
    icy_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    // Output stage
    icy_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ===== rtl/icy_front.sv =====
// Front end: accepts stream bytes, tracks phase and title match, queues results.
`timescale 1ns / 1ps

module icy_front #(
    parameter int INTERVAL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icy_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output icy_pkg::entry_t               q_entry
);

    logic [icy_pkg::CFG_WIDTH+INTERVAL_BITS-1:0] cfg_ext;

    logic [INTERVAL_BITS-1:0] meta_interval_reg;
    icy_pkg::phase_t          phase_reg, phase_next;
    icy_pkg::title_phase_t    title_phase_reg, title_phase_next;
    logic [INTERVAL_BITS-1:0] audio_count_reg, audio_count_next;
    logic [11:0]              meta_left_reg, meta_left_next;
    logic [3:0]               match_pos_reg, match_pos_next;
    logic                     seen_reg, seen_next;

    logic                     accept;
    logic [INTERVAL_BITS-1:0] count_inc;
    logic [7:0]               lc;
    logic [3:0]               match_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Interval register, zero-extended or truncated to INTERVAL_BITS
    assign cfg_ext = {{INTERVAL_BITS{1'b0}}, cfg_wdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            meta_interval_reg <= cfg_ext[INTERVAL_BITS-1:0];
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= icy_pkg::PH_AUDIO;
            title_phase_reg <= icy_pkg::TP_SEARCH;
            audio_count_reg <= '0;
            meta_left_reg   <= '0;
            match_pos_reg   <= '0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            title_phase_reg <= title_phase_next;
            audio_count_reg <= audio_count_next;
            meta_left_reg   <= meta_left_next;
            match_pos_reg   <= match_pos_next;
            seen_reg        <= seen_next;
        end
    end

    assign count_inc = audio_count_reg + {{(INTERVAL_BITS-1){1'b0}}, 1'b1};
    assign match_inc = match_pos_reg + 4'd1;

    // Case-folded byte for the pattern compare
    always_comb
    begin
        if (in_byte inside {[8'h41:8'h5A]})
        begin
            lc = in_byte + icy_pkg::CASE_OFFSET;
        end
        else
        begin
            lc = in_byte;
        end
    end

    // Next state and queued results for the accepted byte
    always_comb
    begin
        phase_next       = phase_reg;
        title_phase_next = title_phase_reg;
        audio_count_next = audio_count_reg;
        meta_left_next   = meta_left_reg;
        match_pos_next   = match_pos_reg;
        seen_next        = seen_reg;
        q_push           = 1'b0;
        q_entry.kind     = icy_pkg::KIND_AUDIO;
        q_entry.data     = in_byte;
        q_entry.two      = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                icy_pkg::PH_LENGTH:
                begin
                    meta_left_next   = {in_byte, 4'b0000};
                    match_pos_next   = '0;
                    title_phase_next = icy_pkg::TP_SEARCH;
                    seen_next        = 1'b0;
                    if (in_byte != 8'h00)
                    begin
                        phase_next = icy_pkg::PH_META;
                    end
                    else
                    begin
                        phase_next       = icy_pkg::PH_AUDIO;
                        audio_count_next = '0;
                    end
                end

                icy_pkg::PH_META:
                begin
                    // padding bytes are skipped
                    if (in_byte != 8'h00)
                    begin
                        case (title_phase_reg)
                            icy_pkg::TP_SEARCH:
                            begin
                                if (match_pos_reg < icy_pkg::PATTERN_LEN &&
                                    lc == icy_pkg::pattern_char(match_pos_reg))
                                begin
                                    if (match_inc >= icy_pkg::PATTERN_LEN)
                                    begin
                                        title_phase_next = icy_pkg::TP_CAPTURE;
                                        match_pos_next   = '0;
                                    end
                                    else
                                    begin
                                        match_pos_next = match_inc;
                                    end
                                end
                                else
                                begin
                                    match_pos_next = (lc == icy_pkg::CHAR_S) ? 4'd1 : 4'd0;
                                end
                            end

                            icy_pkg::TP_CAPTURE:
                            begin
                                if (in_byte == icy_pkg::CHAR_QUOTE)
                                begin
                                    // empty title gives no marker
                                    if (seen_reg)
                                    begin
                                        q_push       = 1'b1;
                                        q_entry.kind = icy_pkg::KIND_TITLE_DONE;
                                        q_entry.data = 8'h00;
                                    end
                                    title_phase_next = icy_pkg::TP_DONE;
                                end
                                else
                                begin
                                    q_push       = 1'b1;
                                    q_entry.kind = icy_pkg::KIND_TITLE_CHAR;
                                    seen_next    = 1'b1;
                                end
                            end

                            default:
                            begin
                            end
                        endcase
                    end

                    meta_left_next = meta_left_reg - 12'd1;
                    if (meta_left_next == 12'd0)
                    begin
                        // block closes with title still open
                        if (title_phase_next == icy_pkg::TP_CAPTURE && seen_next)
                        begin
                            if (q_push)
                            begin
                                q_entry.two = 1'b1;
                            end
                            else
                            begin
                                q_push       = 1'b1;
                                q_entry.kind = icy_pkg::KIND_TITLE_ABANDON;
                                q_entry.data = 8'h00;
                            end
                        end
                        title_phase_next = icy_pkg::TP_DONE;
                        phase_next       = icy_pkg::PH_AUDIO;
                        audio_count_next = '0;
                    end
                end

                default:
                begin
                    // audio phase (also the unused code)
                    phase_next = icy_pkg::PH_AUDIO;
                    q_push     = 1'b1;
                    if (meta_interval_reg != '0)
                    begin
                        if (count_inc == '0 || count_inc >= meta_interval_reg)
                        begin
                            phase_next       = icy_pkg::PH_LENGTH;
                            audio_count_next = '0;
                        end
                        else
                        begin
                            audio_count_next = count_inc;
                        end
                    end
                    else
                    begin
                        audio_count_next = '0;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/icy_queue.sv =====
// Short queue of result groups between the front end and the output stage.
`timescale 1ns / 1ps

module icy_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  icy_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output icy_pkg::entry_t head
);

    icy_pkg::entry_t              slots_reg [icy_pkg::QUEUE_DEPTH];
    logic [icy_pkg::QUEUE_AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [icy_pkg::QUEUE_AW:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[icy_pkg::QUEUE_AW] != rd_ptr_reg[icy_pkg::QUEUE_AW]) &&
                   (wr_ptr_reg[icy_pkg::QUEUE_AW-1:0] == rd_ptr_reg[icy_pkg::QUEUE_AW-1:0]);
    assign head  = slots_reg[rd_ptr_reg[icy_pkg::QUEUE_AW-1:0]];

    assign wr_ptr_next = (push && !full) ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (pop && !empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slots_reg[wr_ptr_reg[icy_pkg::QUEUE_AW-1:0]] <= push_entry;
        end
    end

endmodule

// ===== rtl/icy_back.sv =====
// Output stage: expands queued result groups into single output transactions.
`timescale 1ns / 1ps

module icy_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  icy_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic           valid_reg, valid_next;
    logic           pending_reg, pending_next;
    icy_pkg::kind_t kind_reg, kind_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           load;

    assign load = !valid_reg || out_ready;

    // Pick the next output: a pending abandon marker first, then the queue head
    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        if (load)
        begin
            if (pending_reg)
            begin
                valid_next   = 1'b1;
                pending_next = 1'b0;
                kind_next    = icy_pkg::KIND_TITLE_ABANDON;
                byte_next    = 8'h00;
                last_next    = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next   = 1'b1;
                q_pop        = 1'b1;
                pending_next = q_head.two;
                kind_next    = q_head.kind;
                byte_next    = q_head.data;
                last_next    = !q_head.two;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule
